// ----- rtl/bce_pkg.sv -----
package bce_pkg;

  localparam int DATA_W         = 17;
  localparam int FRAC_BITS      = DATA_W - 1;
  localparam int MAX_POINTS_DEF = 6;
  localparam int NUM_CTRL       = 6;
  localparam int CNT_W          = 3;
  localparam int IDX_W          = 3;

  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

  // register indexes
  localparam logic [IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [IDX_W-1:0] REG_CTRL_Y0     = 3'd1;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 3'd3;
  // entry 0 is rightmost
  localparam logic [NUM_CTRL-1:0][DATA_W-1:0] CTRL_Y_RST = {
    17'd0, 17'd0, 17'd0, 17'd65536, 17'd62259, 17'd0
  };

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

// ----- rtl/bce_cell.sv -----
// One de Casteljau cell: holds one work value, replaces it by the
// interpolation toward its right neighbor on every step.
module bce_cell (
  input  logic                          clk_i,
  input  bce_pkg::cell_ctrl_t           ctrl_i,
  input  logic [bce_pkg::DATA_W-1:0]    load_val_i,
  input  logic [bce_pkg::DATA_W-1:0]    t_i,
  input  logic [bce_pkg::DATA_W-1:0]    right_i,
  output logic [bce_pkg::DATA_W-1:0]    val_o
);

  logic [bce_pkg::DATA_W-1:0]     val_q, val_d;
  logic signed [bce_pkg::DATA_W:0]     diff;
  logic signed [2*bce_pkg::DATA_W+1:0] prod;
  logic signed [2*bce_pkg::DATA_W+1:0] quot;

  always_comb begin
    diff = $signed({1'b0, right_i}) - $signed({1'b0, val_q});
    prod = diff * $signed({1'b0, t_i});
    // arithmetic shift gives floor for negative products
    quot = prod >>> bce_pkg::FRAC_BITS;
    val_d = val_q;
    if (ctrl_i.load) begin
      val_d = load_val_i;
    end else if (ctrl_i.step) begin
      val_d = val_q + quot[bce_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// ----- rtl/bezier_curve_evaluator_core.sv -----
// Each item loads the cell row on input transfer; the row then steps count-1
// times, where count is point_count clamped to [1, MAX_POINTS], and the result
// goes into the output register once that register is free. A new item is taken
// only when idle, once the last result left the row; an item may enter while a result waits.
// Reset (rst_ni, async low): point_count and ctrl_y back to their defaults, no
// item in flight, no result pending.
module bezier_curve_evaluator_core #(
  parameter int MAX_POINTS = bce_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [bce_pkg::DATA_W-1:0]       curve_param_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [bce_pkg::DATA_W-1:0]       curve_y_o,
  // configuration write channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bce_pkg::IDX_W-1:0]        cfg_index_i,
  input  logic [bce_pkg::DATA_W-1:0]       cfg_data_i
);

  localparam int LVL_W = $clog2(MAX_POINTS);

  // controller states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bce_pkg::CNT_W-1:0]                       point_count_q;
  logic [bce_pkg::NUM_CTRL-1:0][bce_pkg::DATA_W-1:0] ctrl_y_q;
  logic                                            cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= bce_pkg::POINT_COUNT_RST;
      ctrl_y_q      <= bce_pkg::CTRL_Y_RST;
    end else if (cfg_xfer) begin
      if (cfg_index_i == bce_pkg::REG_POINT_COUNT) begin
        point_count_q <= cfg_data_i[bce_pkg::CNT_W-1:0];
      end
      for (int i = 0; i < bce_pkg::NUM_CTRL; i++) begin
        if (cfg_index_i == bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(i)) begin
          ctrl_y_q[i] <= cfg_data_i;
        end
      end
      // indexes past the last control point are dropped
    end
  end

  // ---------------------------------------------------------------------------
  // Controller: load the row on transfer, step count-1 times, hand off
  // ---------------------------------------------------------------------------
  logic                        state_q, state_d;
  logic [LVL_W-1:0]            level_q, level_d;
  logic [bce_pkg::DATA_W-1:0]  t_q, t_d;
  logic                        out_valid_q, out_valid_d;
  logic [bce_pkg::DATA_W-1:0]  y_q, y_d;
  logic                        in_xfer, done, out_free;
  logic [LVL_W-1:0]            levels;
  bce_pkg::cell_ctrl_t         cell_ctrl;
  logic [bce_pkg::DATA_W-1:0]  head_val;

  // step count from point_count: zero acts as one, large values saturate
  always_comb begin
    if (point_count_q == '0) begin
      levels = '0;
    end else if (int'(point_count_q) > MAX_POINTS) begin
      levels = LVL_W'(MAX_POINTS - 1);
    end else begin
      levels = LVL_W'(point_count_q - bce_pkg::CNT_W'(1));
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i & in_ready_o;
  assign done       = (state_q == ST_BUSY) && (level_q == '0);
  assign out_free   = ~out_valid_q | out_ready_i;

  assign cell_ctrl.load = in_xfer;
  assign cell_ctrl.step = (state_q == ST_BUSY) && !done;

  always_comb begin
    state_d     = state_q;
    level_d     = level_q;
    t_d         = t_q;
    out_valid_d = out_valid_q;
    y_d         = y_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_BUSY;
          level_d = levels;
          // t above one saturates
          t_d = (curve_param_i > bce_pkg::ONE) ? bce_pkg::ONE : curve_param_i;
        end
      end
      ST_BUSY: begin
        if (level_q != '0) begin
          level_d = level_q - LVL_W'(1);
        end else if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          y_d = (head_val > bce_pkg::ONE) ? bce_pkg::ONE : head_val;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    t_q <= t_d;
    y_q <= y_d;
  end

  assign out_valid_o = out_valid_q;
  assign curve_y_o   = y_q;

  // ---------------------------------------------------------------------------
  // Cell row: cell i holds work[i] and reads work[i+1] from its right neighbor.
  // Every cell steps in parallel; values past the live range never reach cell 0.
  // ---------------------------------------------------------------------------
  logic [MAX_POINTS-1:0][bce_pkg::DATA_W-1:0] cell_val;

  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
    logic [bce_pkg::DATA_W-1:0] load_val;
    logic [bce_pkg::DATA_W-1:0] right_val;

    if (g < bce_pkg::NUM_CTRL) begin : g_ld_reg
      assign load_val = ctrl_y_q[g];
    end else begin : g_ld_zero
      // slot without a register reads as zero
      assign load_val = '0;
    end

    if (g < MAX_POINTS - 1) begin : g_right
      assign right_val = cell_val[g+1];
    end else begin : g_right_end
      assign right_val = '0;
    end

    bce_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .load_val_i (load_val),
      .t_i        (t_q),
      .right_i    (right_val),
      .val_o      (cell_val[g])
    );
  end

  assign head_val = cell_val[0];

endmodule

// ----- tb/bezier_curve_evaluator_core_tb.sv -----
module bezier_curve_evaluator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index just past the last control point register; writes there are dropped.
  localparam logic [bce_pkg::IDX_W-1:0] REG_NONE =
    bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(bce_pkg::NUM_CTRL);
  localparam int CURVE_ORDER_MAX = bce_pkg::MAX_POINTS_DEF;

  // Golden curve model plus the queue of curve_y values still owed by the DUT.
  class curve_scoreboard;
    typedef struct {
      logic [bce_pkg::DATA_W-1:0] t;
      logic [bce_pkg::DATA_W-1:0] y;
    } curve_sample_t;

    logic [bce_pkg::CNT_W-1:0]  point_count;
    logic [bce_pkg::DATA_W-1:0] ctrl_y [bce_pkg::NUM_CTRL];
    curve_sample_t              owed_y [$];
    int                         mismatches;

    function new();
      int k;
      point_count = bce_pkg::POINT_COUNT_RST;
      for (k = 0; k < bce_pkg::NUM_CTRL; k++) ctrl_y[k] = bce_pkg::CTRL_Y_RST[k];
      mismatches = 0;
    endfunction

    function void write_reg(logic [bce_pkg::IDX_W-1:0] idx,
                            logic [bce_pkg::DATA_W-1:0] data);
      if (idx == bce_pkg::REG_POINT_COUNT) begin
        point_count = data[bce_pkg::CNT_W-1:0];
      end else if (idx >= bce_pkg::REG_CTRL_Y0 && idx < REG_NONE) begin
        ctrl_y[idx - bce_pkg::REG_CTRL_Y0] = data;
      end
    endfunction

    // de Casteljau in exact signed math; >>> on longint floors toward -inf
    function logic [bce_pkg::DATA_W-1:0] eval_curve(logic [bce_pkg::DATA_W-1:0] t_in);
      longint pts [CURVE_ORDER_MAX];
      longint t_sat;
      longint prod;
      longint y;
      int     n;
      int     lvl;
      int     i;
      t_sat = (t_in > bce_pkg::ONE) ? longint'(bce_pkg::ONE) : longint'(t_in);
      n = int'(point_count);
      if (n < 1) n = 1;
      if (n > CURVE_ORDER_MAX) n = CURVE_ORDER_MAX;
      for (i = 0; i < n; i++) pts[i] = (i < bce_pkg::NUM_CTRL) ? longint'(ctrl_y[i]) : 0;
      for (lvl = n - 1; lvl > 0; lvl--) begin
        for (i = 0; i < lvl; i++) begin
          prod   = (pts[i+1] - pts[i]) * t_sat;
          pts[i] = pts[i] + (prod >>> bce_pkg::FRAC_BITS);
        end
      end
      y = pts[0];
      if (y < 0) y = 0;
      if (y > longint'(bce_pkg::ONE)) y = longint'(bce_pkg::ONE);
      return bce_pkg::DATA_W'(y);
    endfunction

    function void note_param(logic [bce_pkg::DATA_W-1:0] t);
      curve_sample_t s;
      s.t = t;
      s.y = eval_curve(t);
      owed_y.insert(owed_y.size(), s);
    endfunction

    function void check_y(logic [bce_pkg::DATA_W-1:0] y);
      curve_sample_t s;
      if (owed_y.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: curve_y %0d with no parameter pending", $realtime, y);
        return;
      end
      s = owed_y.pop_front();
      if (y !== s.y) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: curve_y mismatch t=%0d expected %0d got %0d",
                   $realtime, s.t, s.y, y);
      end
    endfunction

    function bit busy();
      return owed_y.size() != 0;
    endfunction

    function bit clean();
      return mismatches == 0 && owed_y.size() == 0;
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [bce_pkg::DATA_W-1:0] curve_param = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [bce_pkg::DATA_W-1:0] curve_y;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [bce_pkg::IDX_W-1:0]  cfg_index = '0;
  logic [bce_pkg::DATA_W-1:0] cfg_data = '0;

  curve_scoreboard sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bezier_curve_evaluator_core u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .curve_param_i (curve_param),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .curve_y_o     (curve_y),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // t mostly inside [0, 1.0]; the endpoints and out-of-range values get extra weight
  // so that the saturation path and bit 16 of the port are well exercised.
  function automatic logic [bce_pkg::DATA_W-1:0] pick_param();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return bce_pkg::ONE;
    if (r < 14)
      return bce_pkg::DATA_W'($urandom_range(int'(bce_pkg::ONE) + 1,
                                             (1 << bce_pkg::DATA_W) - 1));
    return bce_pkg::DATA_W'($urandom_range(0, int'(bce_pkg::ONE)));
  endfunction

  // Control point heights: rails, values above 1.0 (final clamp), and anything between.
  function automatic logic [bce_pkg::DATA_W-1:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return bce_pkg::ONE;
    if (r == 2)
      return bce_pkg::DATA_W'($urandom_range(int'(bce_pkg::ONE) + 1,
                                             (1 << bce_pkg::DATA_W) - 1));
    return bce_pkg::DATA_W'($urandom_range(0, int'(bce_pkg::ONE)));
  endfunction

  // Leaves cfg_valid high so back-to-back writes follow without a gap; the caller
  // drops it once the batch is done.
  task automatic write_reg(input logic [bce_pkg::IDX_W-1:0] idx,
                           input logic [bce_pkg::DATA_W-1:0] data);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    sb.write_reg(idx, data);
  endtask

  // Same idea for the parameter channel: valid only drops when a gap follows.
  task automatic feed_param(input logic [bce_pkg::DATA_W-1:0] t, input bit allow_gap);
    bit took;
    int gap;
    in_valid    <= 1'b1;
    curve_param <= t;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    sb.note_param(t);
    gap = allow_gap ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Config may only change with nothing in flight: every parameter yields exactly
  // one curve_y, so an empty queue means the pipe has drained.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.busy()) @(posedge clk);
  endtask

  // Result side. Values are sampled on the falling edge, when everything is
  // settled, and the transfer is booked on the following rising edge.
  initial begin
    bit                         fire;
    logic [bce_pkg::DATA_W-1:0] y_seen;
    int                         n_results;
    int                         hold;
    bit                         eager;
    n_results = 0;
    hold      = 0;
    eager     = 1'b0;
    forever begin
      @(negedge clk);
      fire   = out_valid && out_ready;
      y_seen = curve_y;
      @(posedge clk);
      if (fire) begin
        sb.check_y(y_seen);
        n_results++;
        // every so often swap between always-ready and random back-pressure
        if (n_results % 150 == 0) eager = !eager;
        // two long holds while the sender keeps pushing, so the pipe backs up
        // all the way to in_ready
        if (n_results == 500) hold = 300;
        else if (n_results == 1100) hold = 150;
        else if (!eager) hold = pick_gap();
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int  ph;
    int  k;
    bit  steady;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- Directed ---
    // Reset curve (3 points: 0, 0.95, 1.0): endpoints, midpoint, one LSB off
    // each end, and t above 1.0 which must saturate.
    feed_param('0, 1'b1);
    feed_param(bce_pkg::ONE, 1'b1);
    feed_param(bce_pkg::ONE >> 1, 1'b1);
    feed_param(bce_pkg::DATA_W'(1), 1'b1);
    feed_param(bce_pkg::ONE - bce_pkg::DATA_W'(1), 1'b1);
    feed_param(bce_pkg::ONE + bce_pkg::DATA_W'(1), 1'b1);
    feed_param('1, 1'b1);
    drain();

    // Point count zero acts as one point; y0 above 1.0 must come back clamped.
    // Upper data bits set to confirm only the count field is kept. The write
    // past the register list must change nothing.
    write_reg(bce_pkg::REG_POINT_COUNT,
              {{(bce_pkg::DATA_W-bce_pkg::CNT_W){1'b1}}, bce_pkg::CNT_W'(0)});
    write_reg(bce_pkg::REG_CTRL_Y0, '1);
    write_reg(REG_NONE, bce_pkg::DATA_W'(12345));
    cfg_valid <= 1'b0;
    feed_param('0, 1'b1);
    feed_param(bce_pkg::DATA_W'(40000), 1'b1);
    feed_param(bce_pkg::ONE, 1'b1);
    drain();

    // Count 7 saturates to six points; mixed rails give falling segments too,
    // which exercises floor on negative differences.
    write_reg(bce_pkg::REG_POINT_COUNT, bce_pkg::DATA_W'(7));
    write_reg(bce_pkg::REG_CTRL_Y0, '0);
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(1), bce_pkg::ONE);
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(2), '1);
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(3), '0);
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(4), bce_pkg::ONE);
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(5), bce_pkg::DATA_W'(12345));
    cfg_valid <= 1'b0;
    feed_param('0, 1'b1);
    feed_param(bce_pkg::DATA_W'(21845), 1'b1);
    feed_param(bce_pkg::ONE, 1'b1);
    feed_param('1, 1'b1);
    drain();

    // Single point, then a straight falling line from 1.0 to 0 at tiny t.
    write_reg(bce_pkg::REG_POINT_COUNT, bce_pkg::DATA_W'(1));
    write_reg(bce_pkg::REG_CTRL_Y0, bce_pkg::ONE);
    cfg_valid <= 1'b0;
    feed_param(bce_pkg::DATA_W'(5), 1'b1);
    drain();
    write_reg(bce_pkg::REG_POINT_COUNT, bce_pkg::DATA_W'(2));
    write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(1), '0);
    cfg_valid <= 1'b0;
    feed_param(bce_pkg::DATA_W'(1), 1'b1);
    feed_param(bce_pkg::DATA_W'(3), 1'b1);
    drain();

    // --- Random ---
    // Each phase: drain, reprogram, then a block of parameters. Point count
    // is always rewritten (random junk in the upper data bits), control
    // points about half the time each.
    for (ph = 0; ph < 14; ph++) begin
      write_reg(bce_pkg::REG_POINT_COUNT,
                {bce_pkg::DATA_W'($urandom_range(0,
                   (1 << (bce_pkg::DATA_W-bce_pkg::CNT_W)) - 1)) << bce_pkg::CNT_W} |
                bce_pkg::DATA_W'($urandom_range(0, (1 << bce_pkg::CNT_W) - 1)));
      for (k = 0; k < bce_pkg::NUM_CTRL; k++) begin
        if ($urandom_range(0, 1))
          write_reg(bce_pkg::REG_CTRL_Y0 + bce_pkg::IDX_W'(k), pick_level());
      end
      if ($urandom_range(0, 3) == 0) write_reg(REG_NONE, bce_pkg::DATA_W'($urandom()));
      cfg_valid <= 1'b0;
      // some phases run with no sender gaps at all
      steady = (ph % 4 == 2);
      for (k = 0; k < 100; k++) feed_param(pick_param(), !steady);
      drain();
    end

    // Everything sent; drain(), then let any stray output show up.
    repeat (2 * CURVE_ORDER_MAX + 4) @(posedge clk);
    if (sb.clean()) begin
      $display("** bezier_curve_evaluator_core: PASSED **");
    end else begin
      $display("** bezier_curve_evaluator_core: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("** bezier_curve_evaluator_core: FAILED **");
    $finish;
  end

endmodule
